[rtl/iphc_pkg.sv]
`default_nettype none
package iphc_pkg;

	localparam int SIZE_BITS     = 16;
	localparam int SUM_BITS      = 20;
	localparam int NUM_WORDS     = 10;
	localparam int COUNT_BITS    = 4;

	localparam logic [COUNT_BITS-1:0] IDX_FIRST    = 4'd0;
	localparam logic [COUNT_BITS-1:0] IDX_TOTLEN   = 4'd1;
	localparam logic [COUNT_BITS-1:0] IDX_TTL      = 4'd4;
	localparam logic [COUNT_BITS-1:0] IDX_CHECKSUM = 4'd5;
	localparam logic [COUNT_BITS-1:0] IDX_LAST     = 4'(NUM_WORDS - 1);

	localparam logic [3:0]  VERSION_V4 = 4'd4;
	localparam logic [3:0]  VERSION_V6 = 4'd6;
	localparam logic [3:0]  MIN_IHL    = 4'd5;
	localparam logic [15:0] MIN_TOTAL  = 16'd20;
	localparam logic [7:0]  MIN_TTL    = 8'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_VERSION  = 3'd1,
		ST_HDRLEN   = 3'd2,
		ST_TOTLEN   = 3'd3,
		ST_TTL      = 3'd4,
		ST_CHECKSUM = 3'd5
	} status_t;

	typedef struct packed {
		logic [SUM_BITS-1:0]  sum;
		logic [7:0]           version_ihl;
		logic [15:0]          total_length;
		logic [7:0]           time_to_live;
		logic [15:0]          stored_checksum;
		logic [SIZE_BITS-1:0] frame_size;
	} hdr_t;

endpackage
`default_nettype wire

[rtl/iphc_word_if.sv]
`default_nettype none
interface iphc_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] header_word;
	logic [15:0] packet_size;

	modport source (output valid, output header_word, output packet_size, input ready);
	modport sink   (input valid, input header_word, input packet_size, output ready);
endinterface
`default_nettype wire

[rtl/iphc_status_if.sv]
`default_nettype none
interface iphc_status_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] computed_checksum;

	modport source (output valid, output status, output computed_checksum, input ready);
	modport sink   (input valid, input status, input computed_checksum, output ready);
endinterface
`default_nettype wire

[rtl/iphc_capture.sv]
`default_nettype none
module iphc_capture (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        word_valid,
	input  wire logic [15:0]                 word_data,
	input  wire logic [15:0]                 word_size,
	output logic                             word_ready,
	output logic                             hdr_valid,
	output iphc_pkg::hdr_t                   hdr,
	input  wire logic                        hdr_ready
);
	import iphc_pkg::*;

	logic [COUNT_BITS-1:0] word_count_q;
	logic [COUNT_BITS-1:0] idx;
	logic [SUM_BITS-1:0]   running_sum_q;
	logic [SUM_BITS-1:0]   sum_base;
	logic [SUM_BITS-1:0]   sum_next;
	logic [7:0]            version_ihl_q;
	logic [15:0]           total_length_q;
	logic [7:0]            time_to_live_q;
	logic [15:0]           stored_checksum_q;
	logic [SIZE_BITS-1:0]  frame_size_q;
	logic                  is_last;
	logic                  take;
	logic                  hdr_valid_q;
	hdr_t                  hdr_q;

	assign idx        = (word_count_q > IDX_LAST) ? IDX_FIRST : word_count_q;
	assign is_last    = (idx == IDX_LAST);
	assign word_ready = !is_last || !hdr_valid_q || hdr_ready;
	assign take       = word_valid && word_ready;

	assign sum_base = (idx == IDX_FIRST) ? '0 : running_sum_q;
	assign sum_next = (idx == IDX_CHECKSUM) ? sum_base
		: sum_base + SUM_BITS'(word_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= IDX_FIRST;
			hdr_valid_q  <= 1'b0;
		end else begin
			if (hdr_valid_q && hdr_ready)
				hdr_valid_q <= 1'b0;
			if (take) begin
				word_count_q <= is_last ? IDX_FIRST : idx + 4'd1;
				if (is_last)
					hdr_valid_q <= 1'b1;
			end
		end
	end

	// header fields, only loaded on a beat
	always_ff @(posedge clk) begin
		if (take) begin
			running_sum_q <= sum_next;
			if (idx == IDX_FIRST) begin
				version_ihl_q <= word_data[15:8];
				frame_size_q  <= SIZE_BITS'(word_size);
			end
			if (idx == IDX_TOTLEN)
				total_length_q <= word_data;
			if (idx == IDX_TTL)
				time_to_live_q <= word_data[15:8];
			if (idx == IDX_CHECKSUM)
				stored_checksum_q <= word_data;
			if (is_last) begin
				hdr_q.sum             <= sum_next;
				hdr_q.version_ihl     <= version_ihl_q;
				hdr_q.total_length    <= total_length_q;
				hdr_q.time_to_live    <= time_to_live_q;
				hdr_q.stored_checksum <= stored_checksum_q;
				hdr_q.frame_size      <= frame_size_q;
			end
		end
	end

	assign hdr_valid = hdr_valid_q;
	assign hdr       = hdr_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= IDX_LAST)
		else $error("word count out of range");

	a_snapshot_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hdr_valid_q) |-> word_count_q == IDX_FIRST)
		else $error("header snapshot without counter restart");

endmodule
`default_nettype wire

[rtl/iphc_judge.sv]
`default_nettype none
module iphc_judge (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           hdr_valid,
	input  wire iphc_pkg::hdr_t hdr,
	output logic                hdr_ready,
	iphc_status_if.source       result
);
	import iphc_pkg::*;

	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [15:0] computed;
	logic [3:0]  version;
	logic [3:0]  ihl;
	logic [SIZE_BITS-1:0] ihl_bytes;
	logic [SIZE_BITS-1:0] total_ext;
	status_t     status_d;
	status_t     status_q;
	logic [15:0] checksum_q;
	logic        result_valid_q;
	logic        hdr_take;

	assign fold1    = 17'(hdr.sum[15:0]) + 17'(hdr.sum[SUM_BITS-1:16]);
	assign fold2    = 17'(fold1[15:0]) + 17'(fold1[16]);
	assign computed = ~fold2[15:0];

	assign version   = hdr.version_ihl[7:4];
	assign ihl       = hdr.version_ihl[3:0];
	assign ihl_bytes = SIZE_BITS'({ihl, 2'b00});
	assign total_ext = SIZE_BITS'(hdr.total_length);

	always_comb begin
		if (version != VERSION_V4 && version != VERSION_V6)
			status_d = ST_VERSION;
		else if (ihl < MIN_IHL || ihl_bytes > hdr.frame_size)
			status_d = ST_HDRLEN;
		else if (hdr.total_length < MIN_TOTAL || total_ext > hdr.frame_size)
			status_d = ST_TOTLEN;
		else if (hdr.time_to_live < MIN_TTL)
			status_d = ST_TTL;
		else if (hdr.stored_checksum == 16'd0)
			status_d = ST_OK;
		else if (computed != hdr.stored_checksum)
			status_d = ST_CHECKSUM;
		else
			status_d = ST_OK;
	end

	assign hdr_ready = !result_valid_q || result.ready;
	assign hdr_take  = hdr_valid && hdr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (hdr_ready) begin
			result_valid_q <= hdr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_take) begin
			status_q   <= status_d;
			checksum_q <= computed;
		end
	end

	assign result.valid             = result_valid_q;
	assign result.status            = status_q;
	assign result.computed_checksum = checksum_q;

	a_fold_done: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid |-> !fold2[16])
		else $error("checksum fold left a carry");

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_take |=> result_valid_q)
		else $error("header taken but no result loaded");

endmodule
`default_nettype wire

[rtl/ipv4_header_checker.sv]
// path: input register, then header snapshot, then result register
// throughput: one header word per cycle unless stalled, one result per ten words
// each word but the checksum adds into a 20-bit running sum, the fold and checks
// run combinationally between the snapshot and the result register
// reset clears the word counter and all valid flags, the next word starts a header
`default_nettype none
module ipv4_header_checker (
	input  wire logic     clk,
	input  wire logic     arst_n,
	iphc_word_if.sink     words,
	iphc_status_if.source result
);
	import iphc_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic [15:0] size_s1;
	logic        cap_ready;
	logic        hdr_valid;
	logic        hdr_ready;
	hdr_t        hdr;

	assign words.ready = !valid_s1 || cap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.ready) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1 <= words.header_word;
			size_s1 <= words.packet_size;
		end
	end

	iphc_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (valid_s1),
		.word_data  (word_s1),
		.word_size  (size_s1),
		.word_ready (cap_ready),
		.hdr_valid  (hdr_valid),
		.hdr        (hdr),
		.hdr_ready  (hdr_ready)
	);

	iphc_judge u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr       (hdr),
		.hdr_ready (hdr_ready),
		.result    (result)
	);

endmodule
`default_nettype wire
